/* src/mm3_pkg.sv */
// package for the 3x3 fixed-point matrix multiplier
// item types, controller command and status structs, func codes, index helper
// no dependencies
package mm3_pkg;

    // func codes of an input item
    localparam logic [1:0] FUNC_LOAD_LEFT  = 2'd0;
    localparam logic [1:0] FUNC_LOAD_RIGHT = 2'd1;
    localparam logic [1:0] FUNC_COMPUTE    = 2'd2;

    // matrix geometry
    localparam int unsigned MAT_DIM     = 3;
    localparam int unsigned MAT_ENTRIES = 9;
    localparam logic [1:0]  LAST_POS    = 2'(MAT_DIM - 1);

    // input item
    typedef struct packed {
        logic [1:0]         func;
        logic [1:0]         row;
        logic [1:0]         col;
        logic signed [31:0] value;
    } t_in_item;

    // result item
    typedef struct packed {
        logic [1:0]         out_row;
        logic [1:0]         out_col;
        logic signed [31:0] product;
        logic               last;
    } t_out_item;

    // controller to datapath commands
    typedef struct packed {
        logic       ld_left;
        logic       ld_right;
        logic [3:0] ld_idx;
        logic       issue;
        logic [1:0] row;
        logic [1:0] col;
        logic [1:0] k;
    } t_ctl_cmd;

    // datapath to controller status
    typedef struct packed {
        logic done;
    } t_ctl_sts;

    // row-major store index of element (r, c)
    function automatic logic [3:0] mat_idx(input logic [1:0] r, input logic [1:0] c);
        return 4'({r, 1'b0}) + 4'(r) + 4'(c);
    endfunction

endpackage

/* src/mm3_ctrl.sv */
// controller for the 3x3 matrix multiplier: decodes items, sequences dot-product terms
// depends on mm3_pkg
module mm3_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  mm3_pkg::t_in_item  i_item,
    input  mm3_pkg::t_ctl_sts  i_sts,
    output mm3_pkg::t_ctl_cmd  o_cmd,
    output logic               o_busy
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ISSUE,
        ST_DRAIN
    } t_state;

    t_state     r_state, n_state;
    logic       r_busy, n_busy;
    logic [1:0] r_row, n_row;
    logic [1:0] r_col, n_col;
    logic [1:0] r_k, n_k;
    logic       accept;
    logic       in_range;

    assign accept   = i_start && !r_busy;
    assign in_range = (i_item.row < 2'(mm3_pkg::MAT_DIM)) && (i_item.col < 2'(mm3_pkg::MAT_DIM));

    // command decode
    always_comb begin
        o_cmd.ld_left  = accept && in_range && (i_item.func == mm3_pkg::FUNC_LOAD_LEFT);
        o_cmd.ld_right = accept && in_range && (i_item.func == mm3_pkg::FUNC_LOAD_RIGHT);
        o_cmd.ld_idx   = mm3_pkg::mat_idx(i_item.row, i_item.col);
        o_cmd.issue    = (r_state == ST_ISSUE);
        o_cmd.row      = r_row;
        o_cmd.col      = r_col;
        o_cmd.k        = r_k;
    end

    // next state and term counters
    always_comb begin
        n_state = r_state;
        n_busy  = r_busy;
        n_row   = r_row;
        n_col   = r_col;
        n_k     = r_k;
        unique case (r_state)
            ST_IDLE: begin
                if (accept && (i_item.func == mm3_pkg::FUNC_COMPUTE)) begin
                    n_state = ST_ISSUE;
                    n_busy  = 1'b1;
                    n_row   = '0;
                    n_col   = '0;
                    n_k     = '0;
                end
            end
            ST_ISSUE: begin
                if (r_k != mm3_pkg::LAST_POS) begin
                    n_k = r_k + 2'd1;
                end else begin
                    n_k = '0;
                    if (r_col != mm3_pkg::LAST_POS) begin
                        n_col = r_col + 2'd1;
                    end else begin
                        n_col = '0;
                        if (r_row != mm3_pkg::LAST_POS) begin
                            n_row = r_row + 2'd1;
                        end else begin
                            n_state = ST_DRAIN;
                        end
                    end
                end
            end
            ST_DRAIN: begin
                if (i_sts.done) begin
                    n_state = ST_IDLE;
                    n_busy  = 1'b0;
                end
            end
            default: begin
                n_state = ST_IDLE;
                n_busy  = 1'b0;
            end
        endcase
    end

    // state and registered outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_busy  <= 1'b0;
            r_row   <= '0;
            r_col   <= '0;
            r_k     <= '0;
        end else begin
            r_state <= n_state;
            r_busy  <= n_busy;
            r_row   <= n_row;
            r_col   <= n_col;
            r_k     <= n_k;
        end
    end

    assign o_busy = r_busy;

endmodule

/* src/mm3_datapath.sv */
// datapath for the 3x3 matrix multiplier: element stores, multiply-accumulate
// pipeline, shift and saturate, write-back row buffer; depends on mm3_pkg
module mm3_datapath #(
    parameter int VALUE_BITS = 32,
    parameter int FRAC_BITS  = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  mm3_pkg::t_in_item  i_item,
    input  mm3_pkg::t_ctl_cmd  i_cmd,
    input  logic               i_cfg_valid,
    input  logic               i_cfg_data,
    output mm3_pkg::t_ctl_sts  o_sts,
    output logic               o_strobe,
    output mm3_pkg::t_out_item o_result
);

    localparam int PB = 2 * VALUE_BITS;
    localparam int AB = PB + 2;
    localparam logic signed [AB-1:0] SAT_MAX = {{(AB - VALUE_BITS + 1){1'b0}},
                                               {(VALUE_BITS - 1){1'b1}}};
    localparam logic signed [AB-1:0] SAT_MIN = {{(AB - VALUE_BITS + 1){1'b1}},
                                               {(VALUE_BITS - 1){1'b0}}};

    logic signed [VALUE_BITS-1:0] r_left  [mm3_pkg::MAT_ENTRIES];
    logic signed [VALUE_BITS-1:0] r_right [mm3_pkg::MAT_ENTRIES];
    logic signed [VALUE_BITS-1:0] r_row_buf [2];
    logic                         r_write_back;

    // pipeline registers
    logic                         r_s1_vld, r_s1_first, r_s1_lastk;
    logic [1:0]                   r_s1_row, r_s1_col;
    logic signed [VALUE_BITS-1:0] r_a, r_b;
    logic                         r_s2_vld, r_s2_first, r_s2_lastk;
    logic [1:0]                   r_s2_row, r_s2_col;
    logic signed [PB-1:0]         r_p;
    logic                         r_s3_vld;
    logic [1:0]                   r_s3_row, r_s3_col;
    logic signed [AB-1:0]         r_acc;
    logic                         r_strobe;
    mm3_pkg::t_out_item           r_result;

    logic signed [AB-1:0]         shifted;
    logic signed [VALUE_BITS-1:0] sat;
    logic signed [AB-1:0]         p_ext;

    // config register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_write_back <= 1'b0;
        end else if (i_cfg_valid) begin
            r_write_back <= i_cfg_data;
        end
    end

    // valid flags of the pipeline
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
            r_s2_vld <= 1'b0;
            r_s3_vld <= 1'b0;
            r_strobe <= 1'b0;
        end else begin
            r_s1_vld <= i_cmd.issue;
            r_s2_vld <= r_s1_vld;
            r_s3_vld <= r_s2_vld && r_s2_lastk;
            r_strobe <= r_s3_vld;
        end
    end

    // operand fetch
    always_ff @(posedge i_clk) begin
        r_a        <= r_left[mm3_pkg::mat_idx(i_cmd.row, i_cmd.k)];
        r_b        <= r_right[mm3_pkg::mat_idx(i_cmd.k, i_cmd.col)];
        r_s1_first <= (i_cmd.k == 2'd0);
        r_s1_lastk <= (i_cmd.k == mm3_pkg::LAST_POS);
        r_s1_row   <= i_cmd.row;
        r_s1_col   <= i_cmd.col;
    end

    // multiply
    always_ff @(posedge i_clk) begin
        r_p        <= r_a * r_b;
        r_s2_first <= r_s1_first;
        r_s2_lastk <= r_s1_lastk;
        r_s2_row   <= r_s1_row;
        r_s2_col   <= r_s1_col;
    end

    // accumulate the three terms
    assign p_ext = AB'(r_p);

    always_ff @(posedge i_clk) begin
        if (r_s2_vld) begin
            r_acc <= r_s2_first ? p_ext : r_acc + p_ext;
        end
        r_s3_row <= r_s2_row;
        r_s3_col <= r_s2_col;
    end

    // shift by the fraction bits and saturate
    always_comb begin
        shifted = r_acc >>> FRAC_BITS;
        if (shifted > SAT_MAX) begin
            sat = SAT_MAX[VALUE_BITS-1:0];
        end else if (shifted < SAT_MIN) begin
            sat = SAT_MIN[VALUE_BITS-1:0];
        end else begin
            sat = shifted[VALUE_BITS-1:0];
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        r_result.out_row <= r_s3_row;
        r_result.out_col <= r_s3_col;
        r_result.product <= 32'(sat);
        r_result.last    <= (r_s3_row == mm3_pkg::LAST_POS) && (r_s3_col == mm3_pkg::LAST_POS);
    end

    // element stores: loads, and write-back one row at a time once the row is done
    always_ff @(posedge i_clk) begin
        if (i_cmd.ld_left) begin
            r_left[i_cmd.ld_idx] <= i_item.value[VALUE_BITS-1:0];
        end else if (r_s3_vld && r_write_back) begin
            if (r_s3_col == mm3_pkg::LAST_POS) begin
                r_left[mm3_pkg::mat_idx(r_s3_row, 2'd0)] <= r_row_buf[0];
                r_left[mm3_pkg::mat_idx(r_s3_row, 2'd1)] <= r_row_buf[1];
                r_left[mm3_pkg::mat_idx(r_s3_row, 2'd2)] <= sat;
            end else begin
                r_row_buf[r_s3_col[0]] <= sat;
            end
        end
        if (i_cmd.ld_right) begin
            r_right[i_cmd.ld_idx] <= i_item.value[VALUE_BITS-1:0];
        end
    end

    assign o_strobe   = r_strobe;
    assign o_result   = r_result;
    assign o_sts.done = r_strobe && r_result.last;

endmodule

/* src/matrix_multiply_3x3_core.sv */
// 3x3 fixed-point matrix multiplier, top level
// contains mm3_ctrl and mm3_datapath; depends on mm3_pkg
//
// usage: an item on i_cmd is taken at a clock edge where start is high and busy
// is low. func load-left / load-right write one element (row, col) of the left or
// right store; loads leave busy low, so loads can run back to back. loads with
// row or col of 3, and func 3, are dropped. a compute item raises busy until its
// last result has left. one shared multiplier takes the 27 dot-product terms one
// per cycle, behind a four-stage fetch, multiply, accumulate and saturate
// pipeline. the nine results leave in row-major order, each on o_result for a
// single cycle with o_strobe; the last carries last=1. the receiver cannot
// stall; results are never held back.
// config: write_back is written over i_cfg_valid / o_cfg_ready (always ready);
// the user must write it only while the block is idle; the block itself does
// not enforce this. with it set, each product row replaces the left store row
// after that row is finished, so all results use the old left.
// reset (synchronous, active low) clears control state and write_back; the
// element stores hold nothing defined until loaded.
module matrix_multiply_3x3_core #(
    parameter int VALUE_BITS = 32,
    parameter int FRAC_BITS  = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  mm3_pkg::t_in_item  i_cmd,
    output logic               o_strobe,
    output mm3_pkg::t_out_item o_result,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic               i_cfg_data
);

    mm3_pkg::t_ctl_cmd ctl_cmd;
    mm3_pkg::t_ctl_sts ctl_sts;

    assign o_cfg_ready = 1'b1;

    // sequencer
    mm3_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_item  (i_cmd),
        .i_sts   (ctl_sts),
        .o_cmd   (ctl_cmd),
        .o_busy  (busy)
    );

    // stores and arithmetic
    mm3_datapath #(
        .VALUE_BITS (VALUE_BITS),
        .FRAC_BITS  (FRAC_BITS)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_item      (i_cmd),
        .i_cmd       (ctl_cmd),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_data  (i_cfg_data),
        .o_sts       (ctl_sts),
        .o_strobe    (o_strobe),
        .o_result    (o_result)
    );

endmodule
